// File: design/lph_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the linear probing hash table
package lph_pkg;

  typedef enum logic {
    CmdInsert = 1'b0,
    CmdLookup = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [63:0] key;
    logic [3:0]  key_len;
    logic [31:0] value;
  } lph_in_t;

  typedef struct packed {
    logic        found;
    logic [31:0] value_out;
    logic [7:0]  slot;
    logic        full_res;
  } lph_out_t;

  // control of the fnv step unit
  typedef struct packed {
    logic load;
    logic step;
  } fnv_ctrl_t;

  localparam logic [63:0] FnvBasis      = 64'hcbf29ce484222325;
  // prime is 2^40 + 0x1b3
  localparam logic [8:0]  FnvPrimeLo    = 9'h1b3;
  localparam int unsigned FnvPrimeShift = 40;

  localparam int unsigned LenW       = 4;
  localparam int unsigned ModBitsCyc = 4;
  localparam int unsigned ModCycles  = 64 / ModBitsCyc;

endpackage

// File: design/lph_fnv.sv
`timescale 1ns / 1ps
// fnv-1 64-bit hash unit, one key byte per cycle while step is asserted
module lph_fnv #(
  parameter int unsigned KEY_BYTES = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lph_pkg::fnv_ctrl_t         ctrl_i,
  input  logic [KEY_BYTES*8-1:0]     key_i,
  output logic [63:0]                hash_o
);
  import lph_pkg::*;

  localparam int unsigned KeyW = KEY_BYTES * 8;

  logic [63:0]     h_q;
  logic [63:0]     h_d;
  logic [KeyW-1:0] sh_q;

  // multiply by the prime as a shift plus a narrow product, then xor the byte
  assign h_d = ((h_q << FnvPrimeShift) + (h_q * FnvPrimeLo)) ^ {56'd0, sh_q[7:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q  <= FnvBasis;
      sh_q <= '0;
    end else if (ctrl_i.load) begin
      h_q  <= FnvBasis;
      sh_q <= key_i;
    end else if (ctrl_i.step) begin
      h_q  <= h_d;
      sh_q <= sh_q >> 8;
    end
  end

  assign hash_o = h_q;

endmodule

// File: design/lph_mod.sv
`timescale 1ns / 1ps
// hash reduction modulo the slot count, a few bits per cycle, or the low bits at once when SLOTS is a power of two
module lph_mod #(
  parameter int unsigned SLOTS = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [63:0]              hash_i,
  output logic                     done_o,
  output logic [$clog2(SLOTS)-1:0] rem_o
);
  import lph_pkg::*;

  localparam int unsigned IdxW   = $clog2(SLOTS);
  localparam bit          IsPow2 = (SLOTS & (SLOTS - 1)) == 0;
  localparam logic [IdxW:0] SlotsW = (IdxW + 1)'(SLOTS);
  localparam logic [3:0]  LastCnt = 4'(ModCycles - 1);

  logic [IdxW-1:0] rem_q;
  logic [IdxW-1:0] rem_d;
  logic [63:0]     sh_q;
  logic [3:0]      cnt_q;
  logic            run_q;
  logic            done_q;

  // restoring remainder: shift one hash bit in, subtract once if over
  always_comb begin
    logic [IdxW:0] acc;
    logic [IdxW:0] t;
    acc = {1'b0, rem_q};
    t   = '0;
    for (int i = 0; i < ModBitsCyc; i++) begin
      t = {acc[IdxW-1:0], sh_q[63-i]};
      if (t >= SlotsW) begin
        t = t - SlotsW;
      end
      acc = t;
    end
    rem_d = acc[IdxW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      sh_q   <= '0;
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      sh_q  <= hash_i;
      cnt_q <= '0;
      if (IsPow2) begin
        rem_q  <= hash_i[IdxW-1:0];
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end else begin
        rem_q  <= '0;
        run_q  <= 1'b1;
        done_q <= 1'b0;
      end
    end else if (run_q) begin
      rem_q <= rem_d;
      sh_q  <= sh_q << ModBitsCyc;
      cnt_q <= cnt_q + 4'd1;
      if (cnt_q == LastCnt) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// File: design/lph_ram.sv
`timescale 1ns / 1ps
// slot memory, one write and one registered read port
module lph_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 101
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/linear_probe_hash_table_unit.sv
`timescale 1ns / 1ps
// top level of the linear probing hash table
//
// in channel: one beat per command, insert-or-overwrite or lookup of a key of
//   up to KEY_BYTES bytes; longer lengths saturate, bytes past the length are
//   ignored and stored as zero
// out channel: one beat per command with found flag, value, slot and full flag
// steps per command: accept, then fnv one byte per cycle through the
//   multiply-xor unit and a hand-off step, then the reduction to a slot index
//   (low hash bits at once when SLOTS is a power of two, else the remainder
//   unit, 4 hash bits per cycle), then a read and a compare per probed slot
//   (single slot memory), then the load of the output register
// one command is in flight at a time; in_ready_o is high only while idle
// the output register lets the next command in while a result waits
// a stalled receiver holds the finished result in the sequencer until the
//   output register frees up
// after reset a clearing pass writes every slot empty, with in_ready_o low;
//   out_valid_o is low after reset
module linear_probe_hash_table_unit #(
  parameter int unsigned SLOTS      = 256,
  parameter int unsigned KEY_BYTES  = 8,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lph_pkg::lph_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lph_pkg::lph_out_t out_o
);
  import lph_pkg::*;

  localparam int unsigned IdxW = $clog2(SLOTS);
  localparam int unsigned KeyW = KEY_BYTES * 8;
  localparam int unsigned EntW = 1 + LenW + KeyW + VALUE_BITS;
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(SLOTS - 1);
  localparam logic [LenW-1:0] MaxLen   = LenW'(KEY_BYTES);

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StHash,
    StMod,
    StRead,
    StCheck,
    StDone
  } state_e;

  state_e                state_q;
  cmd_e                  cmd_q;
  logic [LenW-1:0]       len_q;
  logic [LenW-1:0]       cnt_q;
  logic [KeyW-1:0]       key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [IdxW-1:0]       idx_q;
  logic [IdxW-1:0]       probe_q;
  lph_out_t              res_q;
  lph_out_t              res_d;
  lph_out_t              out_q;
  logic                  out_valid_q;

  logic [LenW-1:0]       len_sat;
  logic [KeyW-1:0]       key_m;
  fnv_ctrl_t             fnv_ctrl;
  logic [63:0]           hash;
  logic                  mod_start;
  logic                  mod_done;
  logic [IdxW-1:0]       mod_rem;

  logic                  ram_we;
  logic [EntW-1:0]       ram_wdata;
  logic [EntW-1:0]       ram_rdata;

  logic                  e_valid;
  logic [LenW-1:0]       e_len;
  logic [KeyW-1:0]       e_key;
  logic [VALUE_BITS-1:0] e_val;
  logic                  match;
  logic                  last_probe;
  logic                  finish;

  // length saturation and masking of bytes past the length
  assign len_sat = (in_i.key_len > MaxLen) ? MaxLen : in_i.key_len;

  always_comb begin
    for (int b = 0; b < KEY_BYTES; b++) begin
      key_m[8*b +: 8] = (LenW'(b) < len_sat) ? in_i.key[8*b +: 8] : 8'd0;
    end
  end

  // hash sequencing
  assign fnv_ctrl.load = (state_q == StIdle) && in_valid_i;
  assign fnv_ctrl.step = (state_q == StHash) && (cnt_q != '0);
  assign mod_start     = (state_q == StHash) && (cnt_q == '0);

  lph_fnv #(
    .KEY_BYTES(KEY_BYTES)
  ) u_fnv (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(fnv_ctrl),
    .key_i (key_m),
    .hash_o(hash)
  );

  lph_mod #(
    .SLOTS(SLOTS)
  ) u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mod_start),
    .hash_i (hash),
    .done_o (mod_done),
    .rem_o  (mod_rem)
  );

  // slot entry layout: valid, length, key, value
  assign {e_valid, e_len, e_key, e_val} = ram_rdata;

  assign match      = e_valid && (e_len == len_q) && (e_key == key_q);
  assign last_probe = (probe_q == LastIdx);
  assign finish     = !e_valid || match || last_probe;

  // insert claims an empty slot or overwrites the equal key
  assign ram_we = (state_q == StClear) ||
                  ((state_q == StCheck) && (cmd_q == CmdInsert) && (!e_valid || match));
  assign ram_wdata = (state_q == StClear) ? '0 : {1'b1, len_q, key_q, val_q};

  lph_ram #(
    .DEPTH(SLOTS),
    .WIDTH(EntW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(idx_q),
    .wdata_i(ram_wdata),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  // result of the current probe, used only when it ends the search
  always_comb begin
    res_d           = '0;
    res_d.found     = match;
    res_d.value_out = ((cmd_q == CmdLookup) && match) ? 32'(e_val) : 32'd0;
    res_d.slot      = (match || ((cmd_q == CmdInsert) && !e_valid)) ? 8'(idx_q) : 8'd0;
    res_d.full_res  = (cmd_q == CmdInsert) && e_valid && !match;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      cmd_q       <= CmdInsert;
      len_q       <= '0;
      cnt_q       <= '0;
      key_q       <= '0;
      val_q       <= '0;
      idx_q       <= '0;
      probe_q     <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // in StDone the handover below refills the output register
      if (out_valid_q && out_ready_i && (state_q != StDone)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StClear: begin
          if (idx_q == LastIdx) begin
            idx_q   <= '0;
            state_q <= StIdle;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        StIdle: begin
          if (in_valid_i) begin
            cmd_q   <= in_i.cmd;
            len_q   <= len_sat;
            cnt_q   <= len_sat;
            key_q   <= key_m;
            val_q   <= VALUE_BITS'(in_i.value);
            state_q <= StHash;
          end
        end
        StHash: begin
          if (cnt_q == '0) begin
            state_q <= StMod;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        StMod: begin
          if (mod_done) begin
            idx_q   <= mod_rem;
            probe_q <= '0;
            state_q <= StRead;
          end
        end
        StRead: begin
          state_q <= StCheck;
        end
        StCheck: begin
          if (finish) begin
            res_q   <= res_d;
            state_q <= StDone;
          end else begin
            // next slot, wrapping round
            idx_q   <= (idx_q == LastIdx) ? '0 : idx_q + 1'b1;
            probe_q <= probe_q + 1'b1;
            state_q <= StRead;
          end
        end
        StDone: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
